/* hdl/tasp_pkg.sv */
// shared types and constants for the three-axis step pulse generator
package tasp_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned COORD_WIDTH_DEF = 24;

  localparam int unsigned PPU_W = 10;
  localparam logic [PPU_W-1:0] PPU_RESET = 10'd10;
  localparam int unsigned FRAC_BITS = 8;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned SIG_W = 2;
  localparam int unsigned M_DATA_W = 8;

  localparam logic [SIG_W-1:0] DIR_UP = 2'd2;
  localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;

  typedef enum logic {
    CMD_MOVE = 1'b0,
    CMD_TICK = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    KIND_DIR    = 2'd0,
    KIND_SLOT   = 2'd1,
    KIND_SPACER = 2'd2,
    KIND_IDLE   = 2'd3
  } word_kind_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

/* hdl/tasp_div.sv */
// shared radix-2 restoring divider, one quotient bit per cycle
module tasp_div #(
  parameter int unsigned WIDTH = tasp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tasp_pkg::div_ctrl_t   ctrl_i,
  output tasp_pkg::div_ctrl_t   ctrl_o,
  input  logic [WIDTH-1:0]      dividend_i,
  input  logic [WIDTH-1:0]      divisor_i,
  output logic [WIDTH-1:0]      quotient_o
);

  localparam int unsigned STEP_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]  rem_q;
  logic [WIDTH-1:0]  quo_q;
  logic [WIDTH-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic [WIDTH:0]    shifted;
  logic [WIDTH:0]    diff;

  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(WIDTH);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[WIDTH]) begin
        rem_q <= diff[WIDTH-1:0];
      end else begin
        rem_q <= shifted[WIDTH-1:0];
      end
      quo_q <= {quo_q[WIDTH-2:0], ~diff[WIDTH]};
    end
  end

  assign ctrl_o.start = busy_q;
  assign ctrl_o.done  = done_q;
  assign quotient_o   = quo_q;

endmodule

/* hdl/three_axis_step_pulse_generator.sv */
// three-axis step/direction pulse generator with iterative move setup
// a tick is answered the cycle after acceptance, one per cycle unless stalled
// a move runs count, divide and emit states, using the shared serial divider
// once for each axis with two or more pulses
// reset clears the train to idle and pulses_per_unit to 10
// a waiting output word holds off the input unless it leaves in the same cycle
module three_axis_step_pulse_generator #(
  parameter int unsigned COUNT_WIDTH = tasp_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned COORD_WIDTH = tasp_pkg::COORD_WIDTH_DEF,
  localparam int unsigned S_DATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tasp_pkg::PPU_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // from_x, from_y, from_z, to_x, to_y, to_z, zero pad
  input  logic [S_DATA_W-1:0]           s_axis_tdata_i,
  // command
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // x_signal, y_signal, z_signal, zero pad
  output logic [tasp_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  // word_kind
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  localparam int unsigned NA      = tasp_pkg::NUM_AXES;
  localparam int unsigned MAG_W   = COORD_WIDTH + 1;
  localparam int unsigned PROD_W  = MAG_W + tasp_pkg::PPU_W;
  localparam int unsigned SH_W    = PROD_W - tasp_pkg::FRAC_BITS;
  localparam int unsigned EXT_W   = (SH_W > COUNT_WIDTH) ? SH_W : COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  state_e                       state_q;
  logic [1:0]                   axis_q;
  logic [tasp_pkg::PPU_W-1:0]   ppu_q;

  logic [MAG_W-1:0]             mag_q     [NA];
  logic                         up_q      [NA];
  logic [COUNT_WIDTH-1:0]       count_q   [NA];
  logic [COUNT_WIDTH-1:0]       spacing_q [NA];
  logic [COUNT_WIDTH-1:0]       phase_q   [NA];
  logic [COUNT_WIDTH-1:0]       most_q;
  logic [COUNT_WIDTH-1:0]       longest_q;
  logic [COUNT_WIDTH-1:0]       slot_q;
  logic                         spacer_q;
  logic                         active_q;

  logic                         out_valid_q;
  tasp_pkg::word_kind_e         out_kind_q;
  logic [3*tasp_pkg::SIG_W-1:0] out_sig_q;
  logic                         out_last_q;

  logic                         in_accept;
  logic                         out_load;
  logic [MAG_W-1:0]             mag_in [NA];
  logic                         up_in  [NA];
  logic [PROD_W-1:0]            prod;
  logic [EXT_W-1:0]             cnt_ext;
  logic [COUNT_WIDTH-1:0]       sat_cnt;
  logic                         slot_bit [NA];
  logic [COUNT_WIDTH:0]         phase_inc [NA];
  logic [COUNT_WIDTH:0]         slot_inc;

  tasp_pkg::div_ctrl_t          div_req;
  tasp_pkg::div_ctrl_t          div_rsp;
  logic [COUNT_WIDTH-1:0]       div_quo;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = ((state_q == ST_IDLE) && in_accept &&
                            (s_axis_tuser_i == tasp_pkg::CMD_TICK)) ||
                           (state_q == ST_EMIT);

  always_comb begin
    logic [COORD_WIDTH-1:0] fr;
    logic [COORD_WIDTH-1:0] tv;
    logic [MAG_W-1:0]       d;
    for (int i = 0; i < NA; i++) begin
      fr = s_axis_tdata_i[i*COORD_WIDTH +: COORD_WIDTH];
      tv = s_axis_tdata_i[(i+NA)*COORD_WIDTH +: COORD_WIDTH];
      d  = {fr[COORD_WIDTH-1], fr} - {tv[COORD_WIDTH-1], tv};
      up_in[i]  = d[MAG_W-1];
      mag_in[i] = d[MAG_W-1] ? (MAG_W'(0) - d) : d;
    end
  end

  assign prod    = PROD_W'(mag_q[axis_q]) * PROD_W'(ppu_q);
  assign cnt_ext = EXT_W'(prod[PROD_W-1:tasp_pkg::FRAC_BITS]);
  assign sat_cnt = (cnt_ext > EXT_W'(CNT_MAX)) ? CNT_MAX : cnt_ext[COUNT_WIDTH-1:0];

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      phase_inc[i] = {1'b0, phase_q[i]} + (COUNT_WIDTH+1)'(1);
      if (count_q[i] == '0) begin
        slot_bit[i] = 1'b0;
      end else if (count_q[i] == COUNT_WIDTH'(1)) begin
        slot_bit[i] = (slot_q == (longest_q >> 1));
      end else begin
        slot_bit[i] = (phase_q[i] == '0);
      end
    end
    slot_inc = {1'b0, slot_q} + (COUNT_WIDTH+1)'(1);
  end

  assign div_req.start = (state_q == ST_DIV) && (count_q[axis_q] >= COUNT_WIDTH'(2));
  assign div_req.done  = 1'b0;

  tasp_div #(
    .WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_req),
    .ctrl_o     (div_rsp),
    .dividend_i (most_q),
    .divisor_i  (count_q[axis_q]),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppu_q       <= tasp_pkg::PPU_RESET;
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= tasp_pkg::KIND_IDLE;
      out_sig_q   <= '0;
      out_last_q  <= 1'b0;
      spacer_q    <= 1'b0;
      active_q    <= 1'b0;
      longest_q   <= '0;
      slot_q      <= '0;
      most_q      <= '0;
      for (int i = 0; i < NA; i++) begin
        mag_q[i]     <= '0;
        up_q[i]      <= 1'b0;
        count_q[i]   <= '0;
        spacing_q[i] <= '0;
        phase_q[i]   <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        ppu_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (s_axis_tuser_i == tasp_pkg::CMD_TICK) begin
              if (!active_q) begin
                out_kind_q <= tasp_pkg::KIND_IDLE;
                out_sig_q  <= '0;
                out_last_q <= 1'b0;
              end else if (!spacer_q) begin
                out_kind_q <= tasp_pkg::KIND_SLOT;
                out_last_q <= 1'b0;
                spacer_q   <= 1'b1;
                for (int i = 0; i < NA; i++) begin
                  out_sig_q[i*tasp_pkg::SIG_W +: tasp_pkg::SIG_W] <=
                    {1'b0, slot_bit[i]};
                  if (count_q[i] >= COUNT_WIDTH'(2)) begin
                    if (phase_inc[i] >= {1'b0, spacing_q[i]}) begin
                      phase_q[i] <= '0;
                    end else begin
                      phase_q[i] <= phase_inc[i][COUNT_WIDTH-1:0];
                    end
                  end
                end
              end else begin
                out_kind_q <= tasp_pkg::KIND_SPACER;
                out_sig_q  <= '0;
                out_last_q <= (slot_inc >= {1'b0, longest_q});
                spacer_q   <= 1'b0;
                slot_q     <= slot_inc[COUNT_WIDTH-1:0];
                if (slot_inc >= {1'b0, longest_q}) begin
                  active_q <= 1'b0;
                end
              end
            end else begin
              for (int i = 0; i < NA; i++) begin
                mag_q[i] <= mag_in[i];
                up_q[i]  <= up_in[i];
              end
              most_q  <= '0;
              axis_q  <= '0;
              state_q <= ST_COUNT;
            end
          end
        end
        ST_COUNT: begin
          count_q[axis_q] <= sat_cnt;
          if (sat_cnt > most_q) begin
            most_q <= sat_cnt;
          end
          if (axis_q == 2'(NA - 1)) begin
            axis_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        ST_DIV: begin
          if (div_req.start) begin
            state_q <= ST_DIV_WAIT;
          end else begin
            spacing_q[axis_q] <= '0;
            if (axis_q == 2'(NA - 1)) begin
              state_q <= ST_EMIT;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            spacing_q[axis_q] <= div_quo;
            if (axis_q == 2'(NA - 1)) begin
              state_q <= ST_EMIT;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_DIV;
            end
          end
        end
        ST_EMIT: begin
          out_kind_q  <= tasp_pkg::KIND_DIR;
          out_last_q  <= (most_q == '0);
          for (int i = 0; i < NA; i++) begin
            out_sig_q[i*tasp_pkg::SIG_W +: tasp_pkg::SIG_W] <=
              up_q[i] ? tasp_pkg::DIR_UP : tasp_pkg::SIG_NONE;
            phase_q[i] <= '0;
          end
          active_q  <= (most_q != '0);
          longest_q <= most_q;
          slot_q    <= '0;
          spacer_q  <= 1'b0;
          state_q   <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = tasp_pkg::M_DATA_W'(out_sig_q);

`ifndef SYNTHESIS
  a_spacer_needs_train : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> !spacer_q)
    else $error("spacer pending without an active train");

  a_div_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_last_spacer_ends_train : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == tasp_pkg::KIND_SPACER) && out_last_q) |-> !active_q)
    else $error("final spacer word while train still active");
`endif

endmodule
